FILE: rtl/jmsw_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jmsw_pkg
// shared constants and helpers for the jpeg marker segment walker
// -----------------------------------------------------------------------------
package jmsw_pkg;

  // width of the internal byte counter, saturates at all ones
  localparam int unsigned SizeBits     = 32;
  localparam int unsigned ImageSizeW   = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned PhaseW       = 3;
  localparam int unsigned SegLenW      = 16;

  // walk phases
  localparam logic [PhaseW-1:0] PhPrefix = 3'd0;
  localparam logic [PhaseW-1:0] PhMarker = 3'd1;
  localparam logic [PhaseW-1:0] PhLenHi  = 3'd2;
  localparam logic [PhaseW-1:0] PhLenLo  = 3'd3;
  localparam logic [PhaseW-1:0] PhSkip   = 3'd4;
  localparam logic [PhaseW-1:0] PhScan   = 3'd5;
  localparam logic [PhaseW-1:0] PhScanFf = 3'd6;

  // result status codes
  localparam logic [StatusW-1:0] StEoi      = 2'd0;
  localparam logic [StatusW-1:0] StNoPrefix = 2'd1;
  localparam logic [StatusW-1:0] StShortLen = 2'd2;
  localparam logic [StatusW-1:0] StTrunc    = 2'd3;

  // marker bytes
  localparam logic [7:0] MkPrefix = 8'hFF;
  localparam logic [7:0] MkSos    = 8'hDA;
  localparam logic [7:0] MkEoi    = 8'hD9;
  localparam logic [7:0] MkStuff  = 8'h00;
  localparam logic [7:0] MkTem    = 8'h01;

  // markers without a length field (eoi handled ahead of this)
  function automatic logic marker_no_len(input logic [7:0] m);
    logic r;
    case (m) inside
      MkStuff, MkTem, [8'hD0:8'hD8]: r = 1'b1;
      default:                       r = 1'b0;
    endcase
    return r;
  endfunction

  // bytes after 0xff inside entropy data that keep the scan going
  function automatic logic scan_escape(input logic [7:0] m);
    logic r;
    case (m) inside
      MkStuff, [8'hD0:8'hD7]: r = 1'b1;
      default:                r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/jpeg_marker_segment_walker_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// jpeg_marker_segment_walker_core
// byte-at-a-time walker over jpeg marker segments with one-deep result register
// -----------------------------------------------------------------------------
// Takes one byte beat per cycle and walks the jpeg element structure: 0xff plus
// a marker, a big-endian length for markers that carry one (segment skipped),
// and entropy-coded data after sos until a real marker shows up. A result beat
// (status, image size, whole-buffer flag) is emitted on eoi, on a missing
// prefix, on a length below two, or when the last byte of the buffer cuts the
// walk short; the walk then restarts with the next byte. A byte flagged as the
// first of the buffer drops any walk in progress silently. Throughput is one
// byte per cycle while no result is held back: the whole walk step updates a
// small phase register and counters at once. The result beat is registered
// and appears in the cycle after its byte beat. The result sits in one output
// register; in_ready_o is high while it is empty or being drained in the same
// cycle, so input stalls only when a result is held back by out_ready_i.
// -----------------------------------------------------------------------------
module jpeg_marker_segment_walker_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        data_byte_i,
  input  logic                              first_of_buffer_i,
  input  logic                              last_of_buffer_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [jmsw_pkg::StatusW-1:0]      status_o,
  output logic [jmsw_pkg::ImageSizeW-1:0]   img_len_o,
  output logic                              spans_whole_buffer_o
);
  import jmsw_pkg::*;

  localparam int unsigned ExtW = (SizeBits > ImageSizeW) ? SizeBits : ImageSizeW;

  // walk state
  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [SizeBits-1:0]  cnt_q, cnt_d;
  logic [SegLenW-1:0]   skip_q, skip_d;
  logic [7:0]           len_hi_q, len_hi_d;
  logic                 sas_q, sas_d;       // enter scan after this segment
  logic                 began_q, began_d;   // image began on a first byte

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic [ImageSizeW-1:0] size_q, size_d;
  logic                 spans_q, spans_d;

  // per-beat working values
  logic                 in_fire;
  logic                 res_hit;
  logic [StatusW-1:0]   res_status;
  logic [PhaseW-1:0]    ph;
  logic [SizeBits-1:0]  cnt_base, cnt_inc;
  logic [SegLenW-1:0]   skip_base, skip_dec, seg_len;
  logic [7:0]           len_hi_base;
  logic                 sas_base, began_base;
  logic [PhaseW-1:0]    ph_next;
  logic [SegLenW-1:0]   skip_next;
  logic [7:0]           len_hi_next;
  logic                 sas_next;
  logic [ExtW-1:0]      cnt_ext;
  logic                 b_last;
  logic [7:0]           b;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign b          = data_byte_i;
  assign b_last     = last_of_buffer_i;

  // a first byte restarts the walk before it is looked at
  assign ph          = first_of_buffer_i ? PhPrefix : phase_q;
  assign len_hi_base = first_of_buffer_i ? 8'h00 : len_hi_q;
  assign skip_base   = first_of_buffer_i ? '0 : skip_q;
  assign sas_base    = first_of_buffer_i ? 1'b0 : sas_q;
  assign cnt_base    = (ph == PhPrefix) ? '0 : cnt_q;
  assign began_base  = (ph == PhPrefix) ? first_of_buffer_i : began_q;
  assign cnt_inc     = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;

  assign seg_len  = {len_hi_base, b};
  assign skip_dec = skip_base - 1'b1;

  // one walk step
  always_comb begin
    res_hit     = 1'b0;
    res_status  = StEoi;
    ph_next     = ph;
    skip_next   = skip_base;
    len_hi_next = len_hi_base;
    sas_next    = sas_base;
    unique case (ph)
      PhPrefix: begin
        if (b_last) begin
          res_hit    = 1'b1;
          res_status = StTrunc;
        end else if (b != MkPrefix) begin
          res_hit    = 1'b1;
          res_status = StNoPrefix;
        end else begin
          ph_next = PhMarker;
        end
      end
      PhMarker, PhScanFf: begin
        if (ph == PhScanFf && scan_escape(b)) begin
          if (b_last) begin
            res_hit    = 1'b1;
            res_status = StTrunc;
          end else begin
            ph_next = PhScan;
          end
        end else if (b == MkEoi) begin
          res_hit    = 1'b1;
          res_status = StEoi;
        end else if (b_last) begin
          res_hit    = 1'b1;
          res_status = StTrunc;
        end else if (marker_no_len(b)) begin
          ph_next = PhPrefix;
        end else begin
          sas_next = (b == MkSos);
          ph_next  = PhLenHi;
        end
      end
      PhLenHi: begin
        len_hi_next = b;
        if (b_last) begin
          res_hit    = 1'b1;
          res_status = StTrunc;
        end else begin
          ph_next = PhLenLo;
        end
      end
      PhLenLo: begin
        if (seg_len < SegLenW'(2)) begin
          res_hit    = 1'b1;
          res_status = StShortLen;
        end else if (b_last) begin
          res_hit    = 1'b1;
          res_status = StTrunc;
        end else if (seg_len == SegLenW'(2)) begin
          ph_next = sas_base ? PhScan : PhPrefix;
        end else begin
          skip_next = seg_len - SegLenW'(2);
          ph_next   = PhSkip;
        end
      end
      PhSkip: begin
        if (b_last) begin
          res_hit    = 1'b1;
          res_status = StTrunc;
        end else begin
          skip_next = skip_dec;
          if (skip_dec == '0) begin
            ph_next = sas_base ? PhScan : PhPrefix;
          end
        end
      end
      PhScan: begin
        if (b_last) begin
          res_hit    = 1'b1;
          res_status = StTrunc;
        end else if (b == MkPrefix) begin
          ph_next = PhScanFf;
        end
      end
      default: begin
        // unused phase code: behave as a fresh walk would on a stray byte
        res_hit    = 1'b1;
        res_status = b_last ? StTrunc : StNoPrefix;
      end
    endcase
  end

  // saturate the counter into the 32-bit size field
  assign cnt_ext = ExtW'(cnt_inc);

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    skip_d      = skip_q;
    len_hi_d    = len_hi_q;
    sas_d       = sas_q;
    began_d     = began_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    size_d      = size_q;
    spans_d     = spans_q;
    if (in_fire) begin
      if (res_hit) begin
        // report and restart
        phase_d     = PhPrefix;
        cnt_d       = '0;
        skip_d      = '0;
        len_hi_d    = 8'h00;
        sas_d       = 1'b0;
        began_d     = 1'b0;
        out_valid_d = 1'b1;
        status_d    = res_status;
        if (res_status == StEoi) begin
          size_d  = (cnt_ext > ExtW'({ImageSizeW{1'b1}})) ? '1 : cnt_ext[ImageSizeW-1:0];
          spans_d = began_base && b_last;
        end else begin
          size_d  = '0;
          spans_d = 1'b0;
        end
      end else begin
        phase_d  = ph_next;
        cnt_d    = cnt_inc;
        skip_d   = skip_next;
        len_hi_d = len_hi_next;
        sas_d    = sas_next;
        began_d  = began_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhPrefix;
      cnt_q       <= '0;
      skip_q      <= '0;
      len_hi_q    <= 8'h00;
      sas_q       <= 1'b0;
      began_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      skip_q      <= skip_d;
      len_hi_q    <= len_hi_d;
      sas_q       <= sas_d;
      began_q     <= began_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    size_q   <= size_d;
    spans_q  <= spans_d;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign img_len_o            = size_q;
  assign spans_whole_buffer_o = spans_q;

  // error results carry no size and no whole-buffer flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StEoi |-> img_len_o == '0 && !spans_whole_buffer_o)
    else $error("error result with nonzero size or span flag");

  // a reported result always leaves the walk at the prefix phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && res_hit |=> phase_q == PhPrefix && cnt_q == '0)
    else $error("walk not restarted after result");

  // skipping always has bytes left to skip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSkip |-> skip_q != '0)
    else $error("skip phase with zero remaining");

  // any walk past the prefix has counted at least one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhPrefix |-> cnt_q != '0)
    else $error("walk in progress with zero byte count");

endmodule
